// ===== rtl/core/stack_vm_instruction_execute_assert.svh =====
// Assertion macros for the stack machine execute block.
// Clocked on clk_i; SVIE_ASSERT is off while rst_ni is low; empty if ASSERT_OFF.
`ifndef STACK_VM_INSTRUCTION_EXECUTE_ASSERT_SVH
`define STACK_VM_INSTRUCTION_EXECUTE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SVIE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`define SVIE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);
`else
`define SVIE_ASSERT(name, prop, msg)
`define SVIE_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== rtl/core/svie_pkg.sv =====
// Shared types and constants of the stack machine execute block.
// No dependencies; used by the top level.
package svie_pkg;

  typedef logic [7:0] byte_t;

  localparam int RAM_DEPTH      = 256;
  localparam int RAM_AW         = $clog2(RAM_DEPTH);
  localparam int FRAME_SIZE     = 32;
  localparam int RETURN_SLOTS   = 2;
  localparam int REGISTER_COUNT = 8;
  localparam int REG_IDX_W      = $clog2(REGISTER_COUNT);

  typedef logic [RAM_AW-1:0]    addr_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam byte_t      FRAME_STEP  = byte_t'(FRAME_SIZE + RETURN_SLOTS);
  localparam logic [8:0] RAM_TOP     = 9'(RAM_DEPTH);

  localparam reg_idx_t REG_FP = reg_idx_t'(4);
  localparam reg_idx_t REG_SP = reg_idx_t'(5);
  localparam reg_idx_t REG_FN = reg_idx_t'(6);
  localparam reg_idx_t REG_PC = reg_idx_t'(7);

  typedef enum logic [2:0] {
    OP_MOV   = 3'd0,
    OP_CAL   = 3'd1,
    OP_RET   = 3'd2,
    OP_REF   = 3'd3,
    OP_ADD   = 3'd4,
    OP_OUT   = 3'd5,
    OP_NOT   = 3'd6,
    OP_EQU   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_VAL = 2'd0,
    KIND_REG = 2'd1,
    KIND_STK = 2'd2,
    KIND_PTR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_KIND     = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_CALLEE   = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRC,
    ST_PTR,
    ST_DST,
    ST_DPTR,
    ST_REG,
    ST_ADD,
    ST_CAL,
    ST_RET1,
    ST_RET2,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/svie_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module svie_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/core/stack_vm_instruction_execute.sv =====
// Execute stage of an 8-bit stack machine: register file, sequencer, data RAM.
// Depends on svie_pkg, svie_ram and stack_vm_instruction_execute_assert.svh.
//
// Usage: present a fetched instruction with start_i while busy_o is low; it
// is taken at that clock edge and busy_o stays high until the result is out.
// The result appears for exactly one cycle with done_o high; the receiver
// cannot hold it off and must take it in that cycle.
// Requests take different paths through the sequencer: an error or a RET in
// main goes straight to the done state, and a move with both operands
// through a pointer takes the longest path.
// Every step through the data RAM is its own state: the RAM has a single port
// with registered read data, and a pointer needs a slot read before the
// target access.
// The main function index is written on the cfg channel, always ready; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset clears the eight registers, the main index and the sequencer; the
// data RAM is not cleared and holds garbage until written.
`include "stack_vm_instruction_execute_assert.svh"

module stack_vm_instruction_execute (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [2:0]      req_type_i,
  input  logic [1:0]      src_kind_i,
  input  svie_pkg::byte_t src_value_i,
  input  logic [1:0]      dst_kind_i,
  input  svie_pkg::byte_t dst_value_i,
  input  svie_pkg::byte_t callee_index_i,
  input  logic            callee_found_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  svie_pkg::byte_t cfg_data_i,
  output logic            done_o,
  output logic            print_valid_o,
  output svie_pkg::byte_t print_value_o,
  output svie_pkg::byte_t next_function_o,
  output svie_pkg::byte_t next_pc_o,
  output logic            finished_o,
  output logic [1:0]      error_code_o
);
  import svie_pkg::*;

  state_e   state_q, state_d;
  byte_t    rf_q [REGISTER_COUNT];
  byte_t    rf_d [REGISTER_COUNT];
  byte_t    main_q;

  op_e      op_q;
  kind_e    sk_q, dk_q;
  byte_t    sv_q, dv_q, callee_q;
  logic     found_q;

  byte_t    x_q, x_d;
  logic     pv_q, pv_d, fin_q, fin_d;
  byte_t    pval_q, pval_d;
  err_e     err_q, err_d;

  logic     accept;
  reg_idx_t rf_ridx;
  byte_t    rf_rdata;
  logic     mem_we;
  addr_t    mem_addr;
  byte_t    mem_wdata, mem_rdata;

  logic [8:0] src_sum, dst_sum, fp_limit;
  addr_t      slot_src, slot_dst;
  byte_t      fp_new;
  logic       cal_overflow;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign src_sum      = {1'b0, rf_q[REG_FP]} + {1'b0, sv_q};
  assign dst_sum      = {1'b0, rf_q[REG_FP]} + {1'b0, dv_q};
  assign slot_src     = src_sum[RAM_AW-1:0];
  assign slot_dst     = dst_sum[RAM_AW-1:0];
  assign fp_limit     = {1'b0, rf_q[REG_FP]} + {1'b0, FRAME_STEP};
  assign cal_overflow = (fp_limit >= RAM_TOP);
  assign fp_new       = fp_limit[7:0];
  assign rf_rdata     = rf_q[rf_ridx];

  svie_ram #(
    .Width (8),
    .Depth (RAM_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (op_q)
          OP_MOV: state_d = (dk_q == KIND_VAL) ? ST_DONE : ST_SRC;
          OP_REF: begin
            if ((sk_q inside {KIND_VAL, KIND_REG}) || dk_q == KIND_VAL) state_d = ST_DONE;
            else state_d = ST_SRC;
          end
          OP_OUT: state_d = ST_SRC;
          OP_CAL: begin
            if (sk_q != KIND_VAL || !found_q || cal_overflow) state_d = ST_DONE;
            else state_d = ST_CAL;
          end
          OP_RET:  state_d = (rf_q[REG_FN] == main_q) ? ST_DONE : ST_RET1;
          default: state_d = ST_REG;
        endcase
      end
      ST_SRC:  state_d = (sk_q == KIND_PTR && op_q != OP_REF) ? ST_PTR : ST_DST;
      ST_PTR:  state_d = ST_DST;
      ST_DST: begin
        if (op_q != OP_OUT && dk_q == KIND_PTR) state_d = ST_DPTR;
        else state_d = ST_DONE;
      end
      ST_DPTR: state_d = ST_DONE;
      ST_REG:  state_d = (op_q == OP_ADD) ? ST_ADD : ST_DONE;
      ST_ADD:  state_d = ST_DONE;
      ST_CAL:  state_d = ST_DONE;
      ST_RET1: state_d = ST_RET2;
      ST_RET2: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rf_d      = rf_q;
    x_d       = x_q;
    pv_d      = pv_q;
    pval_d    = pval_q;
    fin_d     = fin_q;
    err_d     = err_q;
    rf_ridx   = sv_q[REG_IDX_W-1:0];
    mem_we    = 1'b0;
    mem_addr  = slot_src;
    mem_wdata = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pv_d   = 1'b0;
          pval_d = '0;
          fin_d  = 1'b0;
          err_d  = ERR_NONE;
        end
      end
      ST_EXEC: begin
        case (op_q)
          OP_MOV: begin
            if (dk_q == KIND_VAL) err_d = ERR_KIND;
            else rf_d[REG_PC] = rf_q[REG_PC] + 8'd1;
          end
          OP_REF: begin
            if ((sk_q inside {KIND_VAL, KIND_REG}) || dk_q == KIND_VAL) err_d = ERR_KIND;
            else rf_d[REG_PC] = rf_q[REG_PC] + 8'd1;
          end
          OP_CAL: begin
            if (sk_q != KIND_VAL) begin
              err_d = ERR_KIND;
            end else if (!found_q) begin
              err_d = ERR_CALLEE;
            end else if (cal_overflow) begin
              err_d = ERR_OVERFLOW;
            end else begin
              rf_d[REG_PC] = rf_q[REG_PC] + 8'd1;
              rf_d[REG_FP] = fp_new;
              rf_d[REG_SP] = fp_new;
              mem_we       = 1'b1;
              mem_addr     = addr_t'(fp_new - 8'd2);
              mem_wdata    = rf_q[REG_FN];
            end
          end
          OP_RET: begin
            if (rf_q[REG_FN] == main_q) begin
              fin_d = 1'b1;
            end else begin
              mem_addr     = addr_t'(rf_q[REG_FP] - 8'd1);
              rf_d[REG_SP] = rf_q[REG_FP] - 8'd2;
              rf_d[REG_FP] = rf_q[REG_FP] - FRAME_STEP;
            end
          end
          default: rf_d[REG_PC] = rf_q[REG_PC] + 8'd1;
        endcase
      end
      ST_SRC: begin
        case (sk_q)
          KIND_VAL: x_d = sv_q;
          KIND_REG: x_d = rf_rdata;
          KIND_STK: x_d = (op_q == OP_REF) ? byte_t'(slot_src) : mem_rdata;
          default: begin
            mem_addr = mem_rdata[RAM_AW-1:0];
            if (op_q == OP_REF) x_d = byte_t'(mem_rdata[RAM_AW-1:0]);
          end
        endcase
      end
      ST_PTR: x_d = mem_rdata;
      ST_DST: begin
        mem_addr = slot_dst;
        if (op_q == OP_OUT) begin
          pv_d   = 1'b1;
          pval_d = x_q;
        end else begin
          case (dk_q)
            KIND_REG: rf_d[dv_q[REG_IDX_W-1:0]] = x_q;
            KIND_STK: begin
              mem_we    = 1'b1;
              mem_wdata = x_q;
            end
            default: ;
          endcase
        end
      end
      ST_DPTR: begin
        mem_we    = 1'b1;
        mem_addr  = mem_rdata[RAM_AW-1:0];
        mem_wdata = x_q;
      end
      ST_REG: begin
        case (op_q)
          OP_NOT:  rf_d[sv_q[REG_IDX_W-1:0]] = ~rf_rdata;
          OP_EQU:  rf_d[sv_q[REG_IDX_W-1:0]] = (rf_rdata == '0) ? 8'd1 : 8'd0;
          default: x_d = rf_rdata;
        endcase
      end
      ST_ADD: begin
        rf_ridx                     = dv_q[REG_IDX_W-1:0];
        rf_d[dv_q[REG_IDX_W-1:0]] = rf_rdata + x_q;
      end
      ST_CAL: begin
        mem_we       = 1'b1;
        mem_addr     = addr_t'(rf_q[REG_FP] - 8'd1);
        mem_wdata    = rf_q[REG_PC];
        rf_d[REG_FN] = callee_q;
        rf_d[REG_PC] = '0;
      end
      ST_RET1: begin
        rf_d[REG_PC] = mem_rdata;
        mem_addr     = rf_q[REG_SP][RAM_AW-1:0];
      end
      ST_RET2: rf_d[REG_FN] = mem_rdata;
      default: ;
    endcase
  end

  always_comb begin
    busy_o          = (state_q != ST_IDLE);
    done_o          = (state_q == ST_DONE);
    print_valid_o   = pv_q;
    print_value_o   = pval_q;
    next_function_o = rf_q[REG_FN];
    next_pc_o       = rf_q[REG_PC];
    finished_o      = fin_q;
    error_code_o    = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      main_q  <= '0;
      pv_q    <= 1'b0;
      fin_q   <= 1'b0;
      err_q   <= ERR_NONE;
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
      fin_q   <= fin_d;
      err_q   <= err_d;
      rf_q    <= rf_d;
      if (cfg_valid_i && cfg_ready_o) main_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    pval_q <= pval_d;
    if (accept) begin
      op_q     <= op_e'(req_type_i);
      sk_q     <= kind_e'(src_kind_i);
      sv_q     <= src_value_i;
      dk_q     <= kind_e'(dst_kind_i);
      dv_q     <= dst_value_i;
      callee_q <= callee_index_i;
      found_q  <= callee_found_i;
    end
  end

  `SVIE_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accepted request left busy low")
  `SVIE_ASSERT(a_done_pulse, done_o |=> !done_o, "result strobe longer than one cycle")
  `SVIE_ASSERT(a_idle_no_write, mem_we |-> busy_o, "data RAM written while idle")
  `SVIE_ASSERT(a_err_quiet, (done_o && err_q != ERR_NONE) |-> !(pv_q || fin_q), "error with flags")
  `SVIE_ASSERT(a_err_pc_hold, (err_d != ERR_NONE) |=> $stable(rf_q[REG_PC]), "pc moved on an error")
  `SVIE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !done_o, "result strobe during reset")

endmodule
